/* design/stsem_pkg.sv */
package stsem_pkg;

    localparam int MaxTasksDef   = 64;
    localparam int TaskIdBitsDef = 10;

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_INSERT  = 3'd1,
        CMD_MOVE    = 3'd2,
        CMD_REMOVE  = 3'd3,
        CMD_COMPUTE = 3'd4,
        CMD_READ    = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_MV_RD,
        ST_MV_CMP,
        ST_DROP_RD,
        ST_DROP_WR,
        ST_MV_TAIL,
        ST_SCAN_RD,
        ST_SCAN_ACC,
        ST_READ_RD,
        ST_READ_DONE,
        ST_OUT
    } t_state;

    localparam logic signed [47:0] EndLowest = {1'b1, 47'd0};

endpackage

/* design/sorted_task_set_end_min_unit.sv */
// Sorted task list with earliest-completion scan. One command item in, one
// result item out. Entries live in a single-port-read RAM; every walk over
// the list reads one entry at a time through the registered read port:
// insert walks the entries above its slot, move searches then shifts,
// remove shifts the tail, compute scans from the restart index.
// The next item is taken only after the result has been accepted.
module sorted_task_set_end_min_unit #(
    parameter int MaxTasks   = stsem_pkg::MaxTasksDef,
    parameter int TaskIdBits = stsem_pkg::TaskIdBitsDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[2:0], task_id[13:3], earliest_start[45:14], min_duration[76:46],
    // position[82:77]
    input  logic [87:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // end_min[47:0], critical_position[53:48], entry_task[63:54],
    // entry_start[95:64], entry_duration[126:96], entry_count[133:127],
    // error[134]
    output logic [135:0] m_axis_tdata
);
    import stsem_pkg::*;

    localparam int AW = $clog2(MaxTasks);
    localparam int CW = $clog2(MaxTasks + 1);
    localparam int EW = TaskIdBits + 63;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_restart, n_restart;
    logic [CW-1:0] r_idx, n_idx;
    logic [2:0]  r_cmd, n_cmd;
    logic signed [10:0] r_tid, n_tid;
    logic signed [31:0] r_start, n_start;
    logic [30:0] r_dur, n_dur;
    logic [TaskIdBits-1:0] r_keep, n_keep;
    logic signed [47:0] r_end, n_end;
    logic [AW-1:0] r_crit, n_crit;
    logic r_skip, n_skip, r_err, n_err;
    logic [TaskIdBits-1:0] r_etask, n_etask;
    logic signed [31:0] r_estart, n_estart;
    logic [30:0] r_edur, n_edur;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [TaskIdBits-1:0] rd_id;
    logic signed [31:0] rd_start;
    logic [30:0] rd_dur;
    logic id_hit;

    stsem_ram #(.Width(EW), .Depth(MaxTasks)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign rd_id    = rdata[TaskIdBits-1:0];
    assign rd_start = rdata[TaskIdBits +: 32];
    assign rd_dur   = rdata[TaskIdBits+32 +: 31];
    assign id_hit   = !r_tid[10] && (32'(rd_id) == 32'(r_tid));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_restart <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_restart <= n_restart;
        end
        r_idx <= n_idx; r_cmd <= n_cmd; r_tid <= n_tid; r_start <= n_start;
        r_dur <= n_dur; r_keep <= n_keep; r_end <= n_end;
        r_crit <= n_crit; r_skip <= n_skip; r_err <= n_err;
        r_etask <= n_etask; r_estart <= n_estart; r_edur <= n_edur;
    end

    always_comb begin
        n_state = r_state; n_count = r_count; n_restart = r_restart;
        n_idx = r_idx; n_cmd = r_cmd; n_tid = r_tid; n_start = r_start;
        n_dur = r_dur; n_keep = r_keep; n_end = r_end;
        n_crit = r_crit; n_skip = r_skip; n_err = r_err;
        n_etask = r_etask; n_estart = r_estart; n_edur = r_edur;
        we = 1'b0; waddr = r_idx[AW-1:0]; raddr = r_idx[AW-1:0];
        wdata = {rd_dur, rd_start, rd_id};
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd = s_axis_tdata[2:0];
                    n_tid = s_axis_tdata[13:3];
                    n_start = s_axis_tdata[45:14];
                    n_dur = s_axis_tdata[76:46];
                    n_end = '0; n_crit = '0; n_skip = 1'b0; n_err = 1'b0;
                    n_etask = '0; n_estart = '0; n_edur = '0;
                    n_state = ST_OUT;
                    unique case (s_axis_tdata[2:0]) inside
                        CMD_CLEAR: begin
                            n_count = '0; n_restart = '0;
                        end
                        CMD_INSERT: begin
                            if (r_count >= CW'(MaxTasks)) n_err = 1'b1;
                            else begin
                                n_idx = r_count; n_state = ST_INS_RD;
                            end
                        end
                        CMD_MOVE: begin
                            n_idx = '0; n_state = ST_MV_RD;
                        end
                        CMD_REMOVE, CMD_READ: begin
                            if (32'(s_axis_tdata[82:77]) >= 32'(r_count)) n_err = 1'b1;
                            else begin
                                n_idx = CW'(s_axis_tdata[82:77]);
                                n_state = (s_axis_tdata[2:0] == CMD_READ) ?
                                          ST_READ_RD : ST_DROP_RD;
                                if (s_axis_tdata[2:0] == CMD_REMOVE)
                                    n_restart = '0;
                            end
                        end
                        CMD_COMPUTE: begin
                            n_end = EndLowest;
                            n_idx = CW'(r_restart);
                            n_state = ST_SCAN_RD;
                        end
                        default: n_err = 1'b1;
                    endcase
                end
            end
            // insert: r_idx is the hole; examine the entry below it
            ST_INS_RD: begin
                if (r_idx == '0) begin
                    we = 1'b1;
                    wdata = {r_dur, r_start, TaskIdBits'(r_tid)};
                    n_count = r_count + 1'b1;
                    n_restart = '0;
                    n_state = ST_OUT;
                end else begin
                    raddr = AW'(r_idx - 1'b1);
                    n_state = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                we = 1'b1;
                if (rd_start > r_start) begin
                    n_idx = r_idx - 1'b1;
                    n_state = ST_INS_RD;
                end else begin
                    wdata = {r_dur, r_start, TaskIdBits'(r_tid)};
                    n_count = r_count + 1'b1;
                    if (r_idx <= CW'(r_restart)) n_restart = '0;
                    n_state = ST_OUT;
                end
            end
            ST_MV_RD: begin
                if (r_idx >= r_count) n_state = ST_OUT;
                else n_state = ST_MV_CMP;
            end
            ST_MV_CMP: begin
                if (id_hit) begin
                    n_keep = rd_id;
                    n_cmd = CMD_MOVE;
                    n_state = ST_DROP_RD;
                end else begin
                    n_idx = r_idx + 1'b1;
                    raddr = AW'(r_idx + 1'b1);
                    n_state = ST_MV_RD;
                end
            end
            // shift entries above r_idx down by one
            ST_DROP_RD: begin
                if (r_idx + 1'b1 >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_idx = r_count - 1'b1;
                    n_state = (r_cmd == CMD_MOVE) ? ST_MV_TAIL : ST_OUT;
                end else begin
                    raddr = AW'(r_idx + 1'b1);
                    n_state = ST_DROP_WR;
                end
            end
            ST_DROP_WR: begin
                we = 1'b1;
                n_idx = r_idx + 1'b1;
                n_state = ST_DROP_RD;
            end
            ST_MV_TAIL: begin
                we = 1'b1;
                wdata = {r_dur, r_start, r_keep};
                n_count = r_count + 1'b1;
                n_state = ST_OUT;
            end
            ST_SCAN_RD: begin
                if (r_idx >= r_count) n_state = ST_OUT;
                else n_state = ST_SCAN_ACC;
            end
            ST_SCAN_ACC: begin
                if (id_hit) n_skip = 1'b1;
                else if (48'(rd_start) >= r_end) begin
                    n_crit = r_idx[AW-1:0];
                    if (!r_skip) n_restart = r_idx[AW-1:0];
                    n_end = 48'(rd_start) + 48'(rd_dur);
                end else n_end = r_end + 48'(rd_dur);
                n_idx = r_idx + 1'b1;
                raddr = AW'(r_idx + 1'b1);
                n_state = ST_SCAN_RD;
            end
            ST_READ_RD: n_state = ST_READ_DONE;
            ST_READ_DONE: begin
                n_etask = rd_id; n_estart = rd_start; n_edur = rd_dur;
                n_state = ST_OUT;
            end
            ST_OUT: if (m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign m_axis_tdata = {1'b0, r_err, 7'(r_count), r_edur, r_estart,
                           10'(r_etask), 6'(r_crit), r_end};
endmodule

/* design/stsem_ram.sv */
module stsem_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
